/* rtl/lfpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line follower drive core
// Widths, codes and control structs used by the sequencer, the divider, the
// calibration store and the top level.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Frame geometry
  localparam int CHANNELS    = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int LEVEL_W     = SAMPLE_BITS + 1;
  localparam int CHAN_W      = $clog2(CHANNELS);
  localparam int CENTER      = CHANNELS / 2;
  localparam int FIRST_CHAN  = CENTER - 4;
  localparam int LAST_CHAN   = CENTER + 3;

  // Calibration reset levels
  localparam int MIN_RESET = 1 << SAMPLE_BITS;
  localparam int MAX_RESET = 1008;

  // Scaling datapath
  localparam int SCALE_TOP = 50;
  localparam int DIFF_W    = LEVEL_W + 1;
  localparam int NUM_W     = DIFF_W + 6;
  localparam int SCALED_W  = NUM_W + 1;
  localparam int SUM_W     = SCALED_W + 4;

  // Error and correction
  localparam int ERR_W     = 19;
  localparam int ERR_EXT_W = ERR_W + 1;
  localparam int GAIN_W    = 8;
  localparam int PROD_W    = ERR_EXT_W + GAIN_W + 1;
  localparam int CORR_W    = 32;
  localparam int DRIVE_W   = CORR_W + 1;
  localparam int LEVEL_OUT_W = 8;
  localparam int DRIVE_LIMIT = 255;

  // Division by three: the correction magnitude stays below 2^28, so
  // floor(x * ceil(2^30 / 3) / 2^30) is exact over that range
  localparam int THIRD_IN_W   = 28;
  localparam int THIRD_SHIFT  = 30;
  localparam int THIRD_PROD_W = THIRD_IN_W + THIRD_SHIFT;
  localparam int THIRD_RECIP  = 357913942;

  // Shared serial divider
  localparam int DIV_W   = CORR_W;
  localparam int DVSR_W  = DIFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;
  typedef logic [CHANNELS-1:0][LEVEL_W-1:0]     levels_t;

  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_CAL     = 2'd1,
    KIND_STEP    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_D     = 2'd1,
    REG_GAIN_I     = 2'd2,
    REG_BASE_SPEED = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_ACC,
    ST_ERR,
    ST_CORR_P,
    ST_CORR_D,
    ST_CORR_I,
    ST_THIRD,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_D,
    MUL_I
  } mul_sel_t;

  // Sequencer to datapath
  typedef struct packed {
    logic     idle;
    logic     load_operands;
    logic     div_start;
    logic     third_load;
    logic     sum_acc;
    logic     err_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     result_load;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic step_go;
    logic div_done;
    logic span_zero;
    logic last_chan;
    logic out_blocked;
  } status_t;

endpackage

/* rtl/lfpd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_div: shared restoring divider
// Unsigned serial divider, one quotient bit per cycle. Quotient holds after
// done until the next start.
// ----------------------------------------------------------------------------
module lfpd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lfpd_pkg::DIV_W-1:0]       dividend,
  input  logic [lfpd_pkg::DVSR_W-1:0]      divisor,
  output logic                             done,
  output logic [lfpd_pkg::DIV_W-1:0]       quotient
);

  logic                              busy;
  logic [lfpd_pkg::DIV_CNT_W-1:0]    cnt;
  logic [lfpd_pkg::DVSR_W-1:0]       dvsr;
  logic [lfpd_pkg::DVSR_W-1:0]       rem;
  logic [lfpd_pkg::DIV_W-1:0]        quo;
  logic [lfpd_pkg::DVSR_W:0]         rem_sh;
  logic [lfpd_pkg::DVSR_W:0]         rem_sub;
  logic                              fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem, quo[lfpd_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr};
    fits    = rem_sh >= {1'b0, dvsr};
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lfpd_pkg::DIV_CNT_W'(lfpd_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[lfpd_pkg::DVSR_W-1:0] : rem_sh[lfpd_pkg::DVSR_W-1:0];
      quo <= {quo[lfpd_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* rtl/lfpd_cal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_cal: per-channel calibration store
// Holds the minimum and maximum level of every channel, applies restart and
// sample beats, and forms the midpoint line bits of a frame.
// ----------------------------------------------------------------------------
module lfpd_cal (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  lfpd_pkg::kind_t       kind,
  input  lfpd_pkg::frame_t      frame,
  output lfpd_pkg::levels_t     level_min,
  output lfpd_pkg::levels_t     level_max,
  output logic [lfpd_pkg::CHANNELS-1:0] line_bits
);

  // Update levels on an accepted restart or calibration beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfpd_pkg::CHANNELS; i++) begin
        level_min[i] <= lfpd_pkg::LEVEL_W'(lfpd_pkg::MIN_RESET);
        level_max[i] <= lfpd_pkg::LEVEL_W'(lfpd_pkg::MAX_RESET);
      end
    end else if (update) begin
      for (int i = 0; i < lfpd_pkg::CHANNELS; i++) begin
        if (kind == lfpd_pkg::KIND_RESTART) begin
          level_min[i] <= lfpd_pkg::LEVEL_W'(lfpd_pkg::MIN_RESET);
        end else if (kind == lfpd_pkg::KIND_CAL) begin
          if ({1'b0, frame[i]} > level_max[i]) begin
            level_max[i] <= {1'b0, frame[i]};
          end else if ({1'b0, frame[i]} < level_min[i]) begin
            level_min[i] <= {1'b0, frame[i]};
          end
        end
      end
    end
  end

  // Compare each sample against the midpoint of its channel
  always_comb begin
    logic [lfpd_pkg::LEVEL_W:0] mid_sum;
    for (int i = 0; i < lfpd_pkg::CHANNELS; i++) begin
      mid_sum = {1'b0, level_max[i]} + {1'b0, level_min[i]};
      line_bits[lfpd_pkg::CHANNELS-1-i] =
        {1'b0, frame[i]} > mid_sum[lfpd_pkg::LEVEL_W:1];
    end
  end

endmodule

/* rtl/lfpd_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_seq: control step sequencer
// Walks the inner channels through the shared divider, then the error,
// the three gain products, the division by three and the result load.
// ----------------------------------------------------------------------------
module lfpd_seq (
  input  logic               clk,
  input  logic               rst,
  input  lfpd_pkg::status_t  status,
  output lfpd_pkg::ctrl_t    ctrl,
  output lfpd_pkg::state_t   st
);

  lfpd_pkg::state_t state;
  lfpd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfpd_pkg::ST_IDLE: begin
        if (status.step_go) state_next = lfpd_pkg::ST_LOAD;
      end
      lfpd_pkg::ST_LOAD:  state_next = lfpd_pkg::ST_START;
      lfpd_pkg::ST_START: begin
        state_next = status.span_zero ? lfpd_pkg::ST_ACC : lfpd_pkg::ST_WAIT;
      end
      lfpd_pkg::ST_WAIT: begin
        if (status.div_done) state_next = lfpd_pkg::ST_ACC;
      end
      lfpd_pkg::ST_ACC: begin
        state_next = status.last_chan ? lfpd_pkg::ST_ERR : lfpd_pkg::ST_LOAD;
      end
      lfpd_pkg::ST_ERR:    state_next = lfpd_pkg::ST_CORR_P;
      lfpd_pkg::ST_CORR_P: state_next = lfpd_pkg::ST_CORR_D;
      lfpd_pkg::ST_CORR_D: state_next = lfpd_pkg::ST_CORR_I;
      lfpd_pkg::ST_CORR_I: state_next = lfpd_pkg::ST_THIRD;
      lfpd_pkg::ST_THIRD:  state_next = lfpd_pkg::ST_FINISH;
      lfpd_pkg::ST_FINISH: begin
        if (!status.out_blocked) state_next = lfpd_pkg::ST_IDLE;
      end
      default: state_next = lfpd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl               = '0;
    ctrl.mul_sel       = lfpd_pkg::MUL_P;
    ctrl.idle          = state == lfpd_pkg::ST_IDLE;
    ctrl.load_operands = state == lfpd_pkg::ST_LOAD;
    ctrl.div_start     = state == lfpd_pkg::ST_START && !status.span_zero;
    ctrl.third_load    = state == lfpd_pkg::ST_THIRD;
    ctrl.sum_acc       = state == lfpd_pkg::ST_ACC;
    ctrl.err_load      = state == lfpd_pkg::ST_ERR;
    ctrl.result_load   = state == lfpd_pkg::ST_FINISH && !status.out_blocked;
    unique case (state)
      lfpd_pkg::ST_CORR_P: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lfpd_pkg::MUL_P;
      end
      lfpd_pkg::ST_CORR_D: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lfpd_pkg::MUL_D;
      end
      lfpd_pkg::ST_CORR_I: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lfpd_pkg::MUL_I;
      end
      default: begin
        ctrl.mul_en  = 1'b0;
      end
    endcase
  end

  assign st = state;

endmodule

/* rtl/line_follow_pd_drive_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pd_drive_core: calibrated line follower wheel drive
// Calibrates per-channel reflectance ranges and runs PD-style control steps
// that give saturated signed wheel drives and midpoint line bits.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake           Payload
// -------  ---------  ------------------  ------------------------------------
// in       sink       in_valid/in_stall   kind, ten samples
// out      source     out_valid/out_stall levels, forward bits, line bits,
//                                         line_error, correction
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Restart and calibration beats do not stall the input. A control step holds
// in_stall through eight span divisions, each a pass of the shared serial
// divider over the 32-bit dividend (a zero span skips its pass), then error,
// three gain products, a reciprocal multiply for the division by three and
// the finish. Reset restores the gains and calibration levels and clears the
// previous error. A stalled result only holds the last step of the next item.
// ----------------------------------------------------------------------------
module line_follow_pd_drive_core (
  input  logic        clk,
  input  logic        rst,
  // Input frames
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  sample_left_edge,
  input  logic [9:0]  sample_left_4,
  input  logic [9:0]  sample_left_3,
  input  logic [9:0]  sample_left_2,
  input  logic [9:0]  sample_left_1,
  input  logic [9:0]  sample_right_1,
  input  logic [9:0]  sample_right_2,
  input  logic [9:0]  sample_right_3,
  input  logic [9:0]  sample_right_4,
  input  logic [9:0]  sample_right_edge,
  // Results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  left_level,
  output logic        left_forward,
  output logic [7:0]  right_level,
  output logic        right_forward,
  output logic [9:0]  line_bits,
  output logic signed [18:0] line_error,
  output logic signed [31:0] correction,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  lfpd_pkg::ctrl_t   ctrl;
  lfpd_pkg::status_t status;
  lfpd_pkg::state_t  st;

  lfpd_pkg::frame_t  frame_in;
  lfpd_pkg::frame_t  frame_q;
  lfpd_pkg::levels_t level_min;
  lfpd_pkg::levels_t level_max;
  logic [lfpd_pkg::CHANNELS-1:0] line_comb;
  logic              in_accept;
  lfpd_pkg::kind_t   kind_in;

  logic [lfpd_pkg::GAIN_W-1:0] gain_p;
  logic [lfpd_pkg::GAIN_W-1:0] gain_d;
  logic [lfpd_pkg::GAIN_W-1:0] gain_i;
  logic [lfpd_pkg::GAIN_W-1:0] base_speed;

  logic [lfpd_pkg::CHAN_W-1:0]   chan_idx;
  logic [lfpd_pkg::NUM_W-1:0]    num_mag;
  logic [lfpd_pkg::DVSR_W-1:0]   span_mag;
  logic                          q_neg;
  logic                          span_zero;
  logic signed [lfpd_pkg::SUM_W-1:0]  sum8;
  logic signed [lfpd_pkg::ERR_W-1:0]  err_q;
  logic signed [lfpd_pkg::ERR_W-1:0]  prev_err;
  logic signed [lfpd_pkg::CORR_W-1:0] acc;
  logic [lfpd_pkg::CHANNELS-1:0]      line_q;
  logic [lfpd_pkg::THIRD_IN_W-1:0]    third_mag;

  logic                          div_start;
  logic [lfpd_pkg::DIV_W-1:0]    div_dividend;
  logic [lfpd_pkg::DVSR_W-1:0]   div_divisor;
  logic                          div_done;
  logic [lfpd_pkg::DIV_W-1:0]    div_quo;

  // Pack the frame, channel 0 is the left edge
  assign frame_in = {sample_right_edge, sample_right_4, sample_right_3, sample_right_2,
                     sample_right_1, sample_left_1, sample_left_2, sample_left_3,
                     sample_left_4, sample_left_edge};
  assign kind_in   = lfpd_pkg::kind_t'(kind);
  assign in_stall  = !ctrl.idle;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= 8'd2;
      gain_d     <= 8'd8;
      gain_i     <= 8'd1;
      base_speed <= 8'd90;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lfpd_pkg::cfg_reg_t'(cfg_index))
        lfpd_pkg::REG_GAIN_P:     gain_p     <= cfg_data;
        lfpd_pkg::REG_GAIN_D:     gain_d     <= cfg_data;
        lfpd_pkg::REG_GAIN_I:     gain_i     <= cfg_data;
        lfpd_pkg::REG_BASE_SPEED: base_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  lfpd_cal u_cal (
    .clk       (clk),
    .rst       (rst),
    .update    (in_accept),
    .kind      (kind_in),
    .frame     (frame_in),
    .level_min (level_min),
    .level_max (level_max),
    .line_bits (line_comb)
  );

  lfpd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .st     (st)
  );

  lfpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.step_go     = in_accept && kind_in == lfpd_pkg::KIND_STEP;
  assign status.div_done    = div_done;
  assign status.span_zero   = span_zero;
  assign status.last_chan   = chan_idx == lfpd_pkg::CHAN_W'(lfpd_pkg::LAST_CHAN);
  assign status.out_blocked = out_valid && out_stall;

  // Scaling operands of the current channel
  logic signed [lfpd_pkg::DIFF_W-1:0] s_diff;
  logic signed [lfpd_pkg::DIFF_W-1:0] span;
  logic signed [lfpd_pkg::NUM_W-1:0]  num;
  always_comb begin
    s_diff = $signed({2'b00, frame_q[chan_idx]}) - $signed({1'b0, level_min[chan_idx]});
    span   = $signed({1'b0, level_max[chan_idx]}) - $signed({1'b0, level_min[chan_idx]});
    num    = lfpd_pkg::NUM_W'(s_diff) * -lfpd_pkg::NUM_W'(lfpd_pkg::SCALE_TOP);
  end

  // Scaled value and its weighted term
  logic signed [lfpd_pkg::SCALED_W-1:0] q_signed;
  logic signed [lfpd_pkg::SCALED_W-1:0] scaled;
  logic signed [lfpd_pkg::SUM_W-1:0]    term;
  logic                                 right_side;
  logic [1:0]                           shamt;
  always_comb begin
    q_signed   = $signed({1'b0, div_quo[lfpd_pkg::SCALED_W-2:0]});
    if (q_neg) q_signed = -q_signed;
    scaled     = span_zero ? lfpd_pkg::SCALED_W'(lfpd_pkg::SCALE_TOP)
                           : q_signed + lfpd_pkg::SCALED_W'(lfpd_pkg::SCALE_TOP);
    right_side = chan_idx >= lfpd_pkg::CHAN_W'(lfpd_pkg::CENTER);
    shamt      = right_side ? 2'(chan_idx - lfpd_pkg::CHAN_W'(lfpd_pkg::CENTER))
                            : 2'(lfpd_pkg::CHAN_W'(lfpd_pkg::CENTER - 1) - chan_idx);
    term       = lfpd_pkg::SUM_W'(scaled) <<< shamt;
  end

  // Error truncated toward zero
  logic signed [lfpd_pkg::SUM_W-1:0] sum_adj;
  logic signed [lfpd_pkg::SUM_W-1:0] sum_div;
  always_comb begin
    sum_adj = sum8 + (sum8 < 0 ? lfpd_pkg::SUM_W'(7) : lfpd_pkg::SUM_W'(0));
    sum_div = sum_adj >>> 3;
  end

  // Gain product of the current correction term
  logic signed [lfpd_pkg::ERR_EXT_W-1:0] mul_a;
  logic signed [lfpd_pkg::GAIN_W:0]      mul_b;
  logic signed [lfpd_pkg::PROD_W-1:0]    prod;
  always_comb begin
    unique case (ctrl.mul_sel)
      lfpd_pkg::MUL_P: begin
        mul_a = lfpd_pkg::ERR_EXT_W'(err_q);
        mul_b = $signed({1'b0, gain_p});
      end
      lfpd_pkg::MUL_D: begin
        mul_a = lfpd_pkg::ERR_EXT_W'(err_q) - lfpd_pkg::ERR_EXT_W'(prev_err);
        mul_b = $signed({1'b0, gain_d});
      end
      lfpd_pkg::MUL_I: begin
        mul_a = lfpd_pkg::ERR_EXT_W'(err_q) + lfpd_pkg::ERR_EXT_W'(prev_err);
        mul_b = $signed({1'b0, gain_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = lfpd_pkg::PROD_W'(mul_a) * lfpd_pkg::PROD_W'(mul_b);
  end

  // Divider operands: span division of the current channel
  always_comb begin
    div_start    = ctrl.div_start;
    div_dividend = lfpd_pkg::DIV_W'(num_mag);
    div_divisor  = span_mag;
  end

  // Correction magnitude over three by reciprocal multiply
  logic [lfpd_pkg::CORR_W-1:0]       acc_mag;
  logic [lfpd_pkg::THIRD_PROD_W-1:0] third_prod;
  always_comb begin
    acc_mag    = acc[lfpd_pkg::CORR_W-1] ? lfpd_pkg::CORR_W'(-acc) : lfpd_pkg::CORR_W'(acc);
    third_prod = lfpd_pkg::THIRD_PROD_W'(acc_mag[lfpd_pkg::THIRD_IN_W-1:0]) *
                 lfpd_pkg::THIRD_PROD_W'(lfpd_pkg::THIRD_RECIP);
  end

  // Wheel drives from the correction third
  logic signed [lfpd_pkg::DRIVE_W-1:0] third;
  logic signed [lfpd_pkg::DRIVE_W-1:0] base_ext;
  logic signed [lfpd_pkg::DRIVE_W-1:0] ld;
  logic signed [lfpd_pkg::DRIVE_W-1:0] rd;
  logic signed [lfpd_pkg::DRIVE_W-1:0] ld_sat;
  logic signed [lfpd_pkg::DRIVE_W-1:0] rd_sat;
  logic signed [lfpd_pkg::DRIVE_W-1:0] lim;
  always_comb begin
    lim      = lfpd_pkg::DRIVE_W'(lfpd_pkg::DRIVE_LIMIT);
    third    = $signed({{(lfpd_pkg::DRIVE_W - lfpd_pkg::THIRD_IN_W){1'b0}}, third_mag});
    if (acc[lfpd_pkg::CORR_W-1]) third = -third;
    base_ext = $signed({{(lfpd_pkg::DRIVE_W - lfpd_pkg::GAIN_W){1'b0}}, base_speed});
    ld       = base_ext - third;
    rd       = base_ext + third;
    ld_sat   = ld > lim ? lim : (ld < -lim ? -lim : ld);
    rd_sat   = rd > lim ? lim : (rd < -lim ? -lim : rd);
  end

  // Step datapath registers
  always_ff @(posedge clk) begin
    if (status.step_go) begin
      frame_q  <= frame_in;
      line_q   <= line_comb;
      chan_idx <= lfpd_pkg::CHAN_W'(lfpd_pkg::FIRST_CHAN);
      sum8     <= '0;
      acc      <= '0;
    end
    if (ctrl.load_operands) begin
      num_mag   <= num[lfpd_pkg::NUM_W-1] ? lfpd_pkg::NUM_W'(-num) : lfpd_pkg::NUM_W'(num);
      span_mag  <= span[lfpd_pkg::DIFF_W-1] ? lfpd_pkg::DVSR_W'(-span)
                                            : lfpd_pkg::DVSR_W'(span);
      q_neg     <= num[lfpd_pkg::NUM_W-1] ^ span[lfpd_pkg::DIFF_W-1];
      span_zero <= span == '0;
    end
    if (ctrl.sum_acc) begin
      sum8     <= right_side ? sum8 - term : sum8 + term;
      chan_idx <= chan_idx + 1'b1;
    end
    if (ctrl.err_load) begin
      err_q <= sum_div[lfpd_pkg::ERR_W-1:0];
    end
    if (ctrl.mul_en) begin
      acc <= acc + lfpd_pkg::CORR_W'(prod);
    end
    if (ctrl.third_load) begin
      third_mag <= third_prod[lfpd_pkg::THIRD_SHIFT +: lfpd_pkg::THIRD_IN_W];
    end
  end

  // Previous error: cleared by reset, advance on each finished step
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (ctrl.result_load) begin
      prev_err <= err_q;
    end
  end

  // Result register: load on finish, drop on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.result_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.result_load) begin
      left_level    <= ld_sat[lfpd_pkg::DRIVE_W-1] ? lfpd_pkg::LEVEL_OUT_W'(-ld_sat)
                                                   : lfpd_pkg::LEVEL_OUT_W'(ld_sat);
      left_forward  <= ld_sat > 0;
      right_level   <= rd_sat[lfpd_pkg::DRIVE_W-1] ? lfpd_pkg::LEVEL_OUT_W'(-rd_sat)
                                                   : lfpd_pkg::LEVEL_OUT_W'(rd_sat);
      right_forward <= rd_sat > 0;
      line_bits     <= line_q;
      line_error    <= err_q;
      correction    <= acc;
    end
  end

`ifndef SYNTHESIS
  // A control step holds off the input from the next cycle on
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == lfpd_pkg::KIND_STEP) |=> in_stall)
    else $error("input taken during a control step");

  // A new result appears only out of the finish step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == lfpd_pkg::ST_FINISH)
    else $error("result raised outside finish");

  // The divider reports only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> st == lfpd_pkg::ST_WAIT)
    else $error("divider done outside a wait state");

  // Leaving finish always presents a result
  assert property (@(posedge clk) disable iff (rst)
    (st == lfpd_pkg::ST_FINISH && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished step without a result");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line follower drive core
// Sends restart, calibration, ignored and control-step frames with bursty
// valid and a varying output stall pattern. A scoreboard keeps its own copy of
// the calibration levels, gains and previous error, predicts every control
// step and checks each result beat field by field. Gains are rewritten
// between phases while the core is idle, including all-zero and all-max sets.
// ----------------------------------------------------------------------------
module tb_top;
  import lfpd_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1230;
  localparam int PHASES       = 6;

  typedef logic [SAMPLE_BITS-1:0] frame_arr_t [CHANNELS];

  typedef struct packed {
    logic [7:0]  left_level;
    logic        left_fwd;
    logic [7:0]  right_level;
    logic        right_fwd;
    logic [9:0]  line_bits;
    logic [18:0] line_error;
    logic [31:0] correction;
  } drive_t;

  // Predicts wheel drives from its own calibration and gain state
  class drive_scoreboard;
    longint kp, kd, ki, base;
    int     cal_max [CHANNELS];
    int     cal_min [CHANNELS];
    longint last_error;
    drive_t due_drives [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      kp = 2;
      kd = 8;
      ki = 1;
      base = 90;
      foreach (cal_max[i]) begin
        cal_max[i] = MAX_RESET;
        cal_min[i] = MIN_RESET;
      end
      last_error = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        REG_GAIN_P:     kp = val;
        REG_GAIN_D:     kd = val;
        REG_GAIN_I:     ki = val;
        REG_BASE_SPEED: base = val;
        default: ;
      endcase
    endfunction

    // Map a sample onto 50..0 over its calibrated span; a flat span gives 50
    function longint scaled_level(int ch, frame_arr_t s);
      longint span, lvl;
      span = cal_max[ch] - cal_min[ch];
      lvl = s[ch];
      if (span == 0)
        return SCALE_TOP;
      return (lvl - cal_min[ch]) * (-SCALE_TOP) / span + SCALE_TOP;
    endfunction

    function longint limit_drive(longint v);
      if (v > DRIVE_LIMIT)
        return DRIVE_LIMIT;
      if (v < -DRIVE_LIMIT)
        return -DRIVE_LIMIT;
      return v;
    endfunction

    function void note_frame(kind_t k, frame_arr_t s);
      longint sum8, err, corr, third, ld, rd;
      drive_t res;
      case (k)
        KIND_RESTART: begin
          foreach (cal_min[i])
            cal_min[i] = MIN_RESET;
        end
        KIND_CAL: begin
          // a new maximum wins; the minimum is only tried otherwise
          foreach (cal_max[i]) begin
            if (int'(s[i]) > cal_max[i])
              cal_max[i] = s[i];
            else if (int'(s[i]) < cal_min[i])
              cal_min[i] = s[i];
          end
        end
        KIND_STEP: begin
          sum8 = 0;
          for (int w = 1; w <= 4; w++)
            sum8 += (scaled_level(CENTER - w, s) - scaled_level(CENTER - 1 + w, s))
                    * (1 << (w - 1));
          err = sum8 / 8;
          corr = err * kp + (err - last_error) * kd + (err + last_error) * ki;
          third = corr / 3;
          ld = limit_drive(base - third);
          rd = limit_drive(base + third);
          res = '0;
          res.left_level  = 8'(ld > 0 ? ld : -ld);
          res.left_fwd    = (ld > 0);
          res.right_level = 8'(rd > 0 ? rd : -rd);
          res.right_fwd   = (rd > 0);
          for (int i = 0; i < CHANNELS; i++)
            if (int'(s[i]) > (cal_max[i] + cal_min[i]) / 2)
              res.line_bits[CHANNELS-1-i] = 1'b1;
          res.line_error = 19'(err);
          res.correction = 32'(corr);
          last_error = err;
          due_drives.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      checked++;
      if (due_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result beat with no control step pending", $time);
        return;
      end
      want = due_drives.pop_front();
      if (got.left_level !== want.left_level)
        flag("left_level", want.left_level, got.left_level);
      if (got.left_fwd !== want.left_fwd)
        flag("left_forward", want.left_fwd, got.left_fwd);
      if (got.right_level !== want.right_level)
        flag("right_level", want.right_level, got.right_level);
      if (got.right_fwd !== want.right_fwd)
        flag("right_forward", want.right_fwd, got.right_fwd);
      if (got.line_bits !== want.line_bits)
        flag("line_bits", want.line_bits, got.line_bits);
      if (got.line_error !== want.line_error)
        flag("line_error", want.line_error, got.line_error);
      if (got.correction !== want.correction)
        flag("correction", want.correction, got.correction);
    endfunction

    function int pending();
      return due_drives.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_NONE;
  logic [9:0]  sample_left_edge = '0;
  logic [9:0]  sample_left_4 = '0;
  logic [9:0]  sample_left_3 = '0;
  logic [9:0]  sample_left_2 = '0;
  logic [9:0]  sample_left_1 = '0;
  logic [9:0]  sample_right_1 = '0;
  logic [9:0]  sample_right_2 = '0;
  logic [9:0]  sample_right_3 = '0;
  logic [9:0]  sample_right_4 = '0;
  logic [9:0]  sample_right_edge = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  left_level;
  logic        left_forward;
  logic [7:0]  right_level;
  logic        right_forward;
  logic [9:0]  line_bits;
  logic signed [18:0] line_error;
  logic signed [31:0] correction;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_GAIN_P;
  logic [7:0]  cfg_data = '0;

  drive_scoreboard sb = new();
  drive_t seen;
  int     quiet_cycles = 0;
  int     burst_left = 0;
  int     n_steps = 0, n_cal = 0, n_restart = 0, n_ignored = 0, n_settings = 0;

  line_follow_pd_drive_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .sample_left_edge(sample_left_edge), .sample_left_4(sample_left_4),
    .sample_left_3(sample_left_3), .sample_left_2(sample_left_2),
    .sample_left_1(sample_left_1), .sample_right_1(sample_right_1),
    .sample_right_2(sample_right_2), .sample_right_3(sample_right_3),
    .sample_right_4(sample_right_4), .sample_right_edge(sample_right_edge),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_level(left_level), .left_forward(left_forward),
    .right_level(right_level), .right_forward(right_forward),
    .line_bits(line_bits), .line_error(line_error), .correction(correction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame builders
  function automatic frame_arr_t fill_frame(logic [9:0] v);
    frame_arr_t f;
    foreach (f[i])
      f[i] = v;
    return f;
  endfunction

  function automatic logic [9:0] pick_sample(int style, int centre);
    case (style)
      0:       return 10'($urandom_range(0, 1023));
      1:       return 10'(centre + $urandom_range(0, 3));
      2:       return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: return $urandom_range(0, 1) ? 10'($urandom_range(0, 63))
                                           : 10'($urandom_range(960, 1023));
    endcase
  endfunction

  function automatic frame_arr_t random_frame(int style);
    frame_arr_t f;
    int centre;
    centre = $urandom_range(0, 1020);
    foreach (f[i])
      f[i] = pick_sample(style, centre);
    return f;
  endfunction

  task automatic drive_payload(logic [1:0] k, frame_arr_t s);
    kind <= k;
    sample_left_edge <= s[0];
    sample_left_4 <= s[1];
    sample_left_3 <= s[2];
    sample_left_2 <= s[3];
    sample_left_1 <= s[4];
    sample_right_1 <= s[5];
    sample_right_2 <= s[6];
    sample_right_3 <= s[7];
    sample_right_4 <= s[8];
    sample_right_edge <= s[9];
  endtask

  // Insert a random gap between bursts of beats
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drive_payload(2'($urandom_range(0, 3)), random_frame(0));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic send_frame(kind_t k, frame_arr_t s);
    pace();
    @(negedge clk);
    in_valid <= 1'b1;
    drive_payload(k, s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(k, s);
    case (k)
      KIND_RESTART: n_restart++;
      KIND_CAL:     n_cal++;
      KIND_STEP:    n_steps++;
      default:      n_ignored++;
    endcase
  endtask

  // Hold off until every pending result is out and the core has settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(r, v);
  endtask

  task automatic write_gains(logic [7:0] p, logic [7:0] d, logic [7:0] i, logic [7:0] b);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_BASE_SPEED, b);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [7:0] random_gain();
    return ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15))
                                       : 8'($urandom_range(0, 255));
  endfunction

  // Well-formed calibrate-then-steer sequences with some noise mixed in
  task automatic run_sequences(int quota);
    int done_items, n, style;
    kind_t k;
    done_items = 0;
    while (done_items < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          k = kind_t'($urandom_range(0, 3));
          send_frame(k, random_frame($urandom_range(0, 3)));
          if (k != KIND_NONE)
            done_items++;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send_frame(KIND_RESTART, random_frame(0));
          done_items++;
        end
        style = $urandom_range(0, 3);
        n = $urandom_range(0, 6);
        repeat (n) begin
          send_frame(KIND_CAL, random_frame(style));
          done_items++;
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_frame(KIND_STEP, random_frame($urandom_range(0, 3)));
          done_items++;
        end
      end
    end
  endtask

  // Check result beats
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = {left_level, left_forward, right_level, right_forward,
              line_bits, line_error, correction};
      sb.check_result(seen);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern changes per segment, one long hold-off
  initial begin
    int mode, seg;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && sb.checked >= 60) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 300);
      for (int c = 0; c < seg; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= (c % 5 < 3);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    frame_arr_t f;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // inverted spans straight out of reset, then an ignored kind
    send_frame(KIND_STEP, fill_frame(10'd0));
    send_frame(KIND_STEP, fill_frame(10'd1023));
    send_frame(KIND_NONE, random_frame(0));
    // above max and below min at once: only the max moves, then a flat span
    send_frame(KIND_CAL, fill_frame(10'd1010));
    send_frame(KIND_CAL, fill_frame(10'd1010));
    send_frame(KIND_STEP, random_frame(0));
    // restart ignores its samples; then calibrate over the full range
    send_frame(KIND_RESTART, fill_frame(10'd1023));
    send_frame(KIND_CAL, fill_frame(10'd0));
    send_frame(KIND_CAL, fill_frame(10'd1023));
    f = fill_frame(10'd0);
    for (int i = CENTER; i < CHANNELS; i++)
      f[i] = 10'd1023;
    send_frame(KIND_STEP, f);
    f = fill_frame(10'd1023);
    for (int i = CENTER; i < CHANNELS; i++)
      f[i] = 10'd0;
    send_frame(KIND_STEP, f);
    foreach (f[i])
      f[i] = (i % 2) ? 10'h155 : 10'h2AA;
    send_frame(KIND_STEP, f);
    // samples right at and just over the midpoint
    foreach (f[i])
      f[i] = (i % 2) ? 10'd511 : 10'd512;
    send_frame(KIND_STEP, f);

    // zero gains and zero base give a zero drive
    drain();
    write_gains(8'd0, 8'd0, 8'd0, 8'd0);
    send_frame(KIND_STEP, random_frame(0));

    // full gains saturate both ways
    drain();
    write_gains(8'd255, 8'd255, 8'd255, 8'd255);
    f = fill_frame(10'd0);
    for (int i = CENTER; i < CHANNELS; i++)
      f[i] = 10'd1023;
    send_frame(KIND_STEP, f);
    f = fill_frame(10'd1023);
    for (int i = CENTER; i < CHANNELS; i++)
      f[i] = 10'd0;
    send_frame(KIND_STEP, f);
    send_frame(KIND_STEP, fill_frame(10'd0));

    // random phases, each under its own gain setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       write_gains(8'd255, 8'd255, 8'd255, 8'd255);
        1:       write_gains(8'd0, 8'd0, 8'd0, 8'd0);
        default: write_gains(random_gain(), random_gain(), random_gain(),
                             8'($urandom_range(0, 255)));
      endcase
      run_sequences(RANDOM_ITEMS / PHASES);
    end

    drain();
    if (sb.pending() != 0)
      sb.mismatches += sb.pending();
    $display("Frames: %0d steps, %0d calibration, %0d restarts, %0d ignored",
             n_steps, n_cal, n_restart, n_ignored);
    $display("Checked %0d drive results over %0d gain settings, %0d mismatches",
             sb.checked, n_settings, sb.mismatches);
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
